// ===== rtl/core/ctd_pkg.sv =====
// Shared types and constants for the compare timer device.
// Holds the item kind codes, register offsets, control bit positions and the item struct.
// No dependencies.
`default_nettype none

package ctd_pkg;

  // Width of the external data fields
  localparam int FIELD_BITS = 32;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_IDLE  = 2'd3
  } kind_t;

  // Register offsets
  localparam logic [6:0] OFF_BASE    = 7'h00;
  localparam logic [6:0] OFF_END     = 7'h01;
  localparam logic [6:0] OFF_CTRL    = 7'h02;
  localparam logic [6:0] OFF_START   = 7'h03;
  localparam logic [6:0] OFF_ENDCYC  = 7'h04;
  localparam logic [6:0] OFF_PERIOD  = 7'h05;
  localparam logic [6:0] OFF_ELAPSED = 7'h06;
  localparam logic [6:0] OFF_RS      = 7'h12;
  localparam logic [6:0] OFF_ENABLE  = 7'h22;
  localparam logic [6:0] OFF_WAIT    = 7'h32;
  localparam logic [6:0] OFF_REPEAT  = 7'h42;

  // Control word bit positions
  localparam int BIT_RS     = 0;
  localparam int BIT_ENABLE = 1;
  localparam int BIT_WAIT   = 2;
  localparam int BIT_REPEAT = 3;

  // Configuration register indexes
  localparam logic CFG_RESET_BASE = 1'b0;
  localparam logic CFG_WINDOW_LEN = 1'b1;

  // Configuration reset values
  localparam logic [FIELD_BITS-1:0] RESET_BASE   = 32'h0000_0000;
  localparam logic [FIELD_BITS-1:0] RESET_LENGTH = 32'h0000_0010;

  // One input item
  typedef struct packed {
    kind_t                  kind;
    logic [6:0]             reg_offset;
    logic [FIELD_BITS-1:0]  write_data;
    logic [FIELD_BITS-1:0]  now_cycle;
  } item_t;

  // Timer status seen by the top level
  typedef struct packed {
    logic enable;
    logic waiting;
  } tstat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ctd_timer.sv =====
// Timer state and per-item update logic of the compare timer device.
// Holds control bits, start/end cycle, register window and configuration registers.
// Depends on ctd_pkg.
`default_nettype none

module ctd_timer import ctd_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  step,
  input  wire item_t                 item,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [FIELD_BITS-1:0] cfg_wdata,
  output logic [FIELD_BITS-1:0]      read_data,
  output logic                       irq,
  output tstat_t                     status
);

  logic [3:0]            ctrl_r, ctrl_nxt;
  logic [WORD_BITS-1:0]  start_r, start_nxt;
  logic [WORD_BITS-1:0]  end_r, end_nxt;
  logic [WORD_BITS-1:0]  wbase_r, wbase_nxt;
  logic [WORD_BITS-1:0]  wend_r, wend_nxt;
  logic [FIELD_BITS-1:0] rbase_r, rbase_nxt;
  logic [FIELD_BITS-1:0] wlen_r, wlen_nxt;

  logic [WORD_BITS-1:0]  data_w;
  logic [WORD_BITS-1:0]  now_w;
  logic [WORD_BITS-1:0]  period_w;
  logic [WORD_BITS-1:0]  rd_w;

  // Window end from a base and a length, wrapping at the word width
  function automatic logic [WORD_BITS-1:0] win_end(input logic [FIELD_BITS-1:0] base,
                                                   input logic [FIELD_BITS-1:0] len);
    win_end = WORD_BITS'(base) + WORD_BITS'(len) - WORD_BITS'(1);
  endfunction

  assign data_w   = WORD_BITS'(item.write_data);
  assign now_w    = WORD_BITS'(item.now_cycle);
  assign period_w = end_r - start_r + WORD_BITS'(1);

  // Read mux
  always_comb begin
    case (item.reg_offset)
      OFF_BASE:    rd_w = wbase_r;
      OFF_END:     rd_w = wend_r;
      OFF_CTRL:    rd_w = WORD_BITS'(ctrl_r);
      OFF_RS:      rd_w = WORD_BITS'(ctrl_r[BIT_RS]);
      OFF_ENABLE:  rd_w = WORD_BITS'(ctrl_r[BIT_ENABLE]);
      OFF_WAIT:    rd_w = WORD_BITS'(ctrl_r[BIT_WAIT]);
      OFF_REPEAT:  rd_w = WORD_BITS'(ctrl_r[BIT_REPEAT]);
      OFF_START:   rd_w = start_r;
      OFF_ENDCYC:  rd_w = end_r;
      OFF_PERIOD:  rd_w = period_w;
      OFF_ELAPSED: rd_w = now_w - start_r;
      default:     rd_w = '0;
    endcase
  end

  // Next state for one item, or for a configuration write
  always_comb begin
    ctrl_nxt  = ctrl_r;
    start_nxt = start_r;
    end_nxt   = end_r;
    wbase_nxt = wbase_r;
    wend_nxt  = wend_r;
    rbase_nxt = rbase_r;
    wlen_nxt  = wlen_r;
    read_data = '0;
    irq       = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_RESET_BASE: begin
          rbase_nxt = cfg_wdata;
          wbase_nxt = WORD_BITS'(cfg_wdata);
          wend_nxt  = win_end(cfg_wdata, wlen_r);
        end
        CFG_WINDOW_LEN: begin
          wlen_nxt  = cfg_wdata;
          wbase_nxt = WORD_BITS'(rbase_r);
          wend_nxt  = win_end(rbase_r, cfg_wdata);
        end
        default: ;
      endcase
    end else if (step) begin
      unique case (item.kind)
        KIND_TICK: begin
          // Expire an enabled timer whose end lies behind now
          if (ctrl_r[BIT_ENABLE] && (end_r < now_w)) begin
            ctrl_nxt[BIT_ENABLE] = 1'b0;
            ctrl_nxt[BIT_WAIT]   = 1'b1;
            irq                  = 1'b1;
          end
        end
        KIND_READ: begin
          read_data = FIELD_BITS'(rd_w);
        end
        KIND_WRITE: begin
          unique case (item.reg_offset)
            OFF_BASE: begin
              // Move the window, keep its length, clear the timer
              wbase_nxt = data_w;
              wend_nxt  = data_w + wend_r - wbase_r;
              ctrl_nxt  = '0;
              start_nxt = '0;
              end_nxt   = '0;
            end
            OFF_RS:     ctrl_nxt[BIT_RS]     = data_w[0];
            OFF_ENABLE: ctrl_nxt[BIT_ENABLE] = data_w[0];
            OFF_REPEAT: ctrl_nxt[BIT_REPEAT] = data_w[0];
            OFF_WAIT: begin
              ctrl_nxt[BIT_WAIT] = data_w[0];
              // Acknowledge of a pending expiry: restart or clear
              if (ctrl_r[BIT_WAIT] && (data_w == '0)) begin
                if (ctrl_r[BIT_REPEAT]) begin
                  ctrl_nxt             = '0;
                  ctrl_nxt[BIT_ENABLE] = 1'b1;
                  start_nxt            = now_w;
                  end_nxt              = now_w + end_r - start_r;
                end else begin
                  ctrl_nxt  = '0;
                  start_nxt = '0;
                  end_nxt   = '0;
                end
              end
            end
            OFF_START: begin
              if (data_w == '0) begin
                ctrl_nxt  = '0;
                start_nxt = '0;
                end_nxt   = '0;
              end else begin
                start_nxt = now_w;
                end_nxt   = now_w + data_w - WORD_BITS'(1);
              end
            end
            default: ;
          endcase
        end
        KIND_IDLE: ;
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      start_r <= '0;
      end_r   <= '0;
      rbase_r <= RESET_BASE;
      wlen_r  <= RESET_LENGTH;
      wbase_r <= WORD_BITS'(RESET_BASE);
      wend_r  <= win_end(RESET_BASE, RESET_LENGTH);
    end else begin
      ctrl_r  <= ctrl_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      rbase_r <= rbase_nxt;
      wlen_r  <= wlen_nxt;
      wbase_r <= wbase_nxt;
      wend_r  <= wend_nxt;
    end
  end

  assign status.enable  = ctrl_r[BIT_ENABLE];
  assign status.waiting = ctrl_r[BIT_WAIT];

endmodule

`default_nettype wire

// ===== rtl/core/compare_timer_device.sv =====
// Compare timer device: input register, timer update, output register.
// Each item is held in the input register, then its timer result in the result register.
// Throughput: one item per cycle while the result channel does not stall.
// Reset (synchronous, rst_n low) clears timer control, start and end, and loads the
// register window from the reset base and window length defaults (base 0, length 16).
// Depends on ctd_pkg and ctd_timer.
`default_nettype none

module compare_timer_device import ctd_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input channel
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [71:0]           in_tdata,   // reg_offset[6:0], write_data[38:7], now_cycle[70:39]
  input  wire logic [1:0]            in_tuser,   // kind[1:0]
  // Result channel
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [FIELD_BITS-1:0]      out_tdata,  // read_data[31:0]
  output logic                       out_tuser,  // irq[0]
  // Configuration port
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [FIELD_BITS-1:0] cfg_wdata
);

  logic                  in_valid_r;
  item_t                 in_item_r;
  logic                  out_valid_r;
  logic [FIELD_BITS-1:0] out_data_r;
  logic                  out_irq_r;

  item_t                 item_in;
  logic                  advance;
  logic [FIELD_BITS-1:0] t_read_data;
  logic                  t_irq;
  tstat_t                t_status;

  // Unpack the incoming transfer
  assign item_in.kind       = kind_t'(in_tuser);
  assign item_in.reg_offset = in_tdata[6:0];
  assign item_in.write_data = in_tdata[38:7];
  assign item_in.now_cycle  = in_tdata[70:39];

  // Item moves into the timer when the result register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_item_r <= item_in;
    end
  end

  ctd_timer #(
    .WORD_BITS (WORD_BITS)
  ) u_timer (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (in_item_r),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .read_data (t_read_data),
    .irq       (t_irq),
    .status    (t_status)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= t_read_data;
      out_irq_r  <= t_irq;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_irq_r;

  // An expiring tick leaves the timer disabled and waiting
  a_irq_state: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && t_irq) |=> (!t_status.enable && t_status.waiting))
    else $error("timer state not updated after expiry");

  // Interrupt only comes from an enabled timer
  a_irq_enabled: assert property (@(posedge clk) disable iff (!rst_n)
    t_irq |-> t_status.enable)
    else $error("irq raised while timer disabled");

  // An interrupt result never carries read data
  a_irq_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata == '0))
    else $error("irq result with nonzero data");

  // A held input item stays held while the result side stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !advance) |=> in_valid_r)
    else $error("pending item lost");

endmodule

`default_nettype wire
